[src/aesd_pkg.sv]
// Package for the AES-128 block decryptor: types, S-box tables and GF(2^8) helpers.
// Depends on nothing; used by every module under src.
package aesd_pkg;

	localparam int unsigned HALF_W  = 64;
	localparam int unsigned BLOCK_W = 128;
	localparam int unsigned NROUNDS = 10;

	// Configuration register indexes.
	localparam logic [0:0] REG_KEY_UPPER = 1'b0;
	localparam logic [0:0] REG_KEY_LOWER = 1'b1;

	// One classified block passed from the front to the back.
	typedef struct packed {
		logic [BLOCK_W-1:0] block;
	} blk_t;

	// Inverse S-box as a function over a constant table.
	function automatic logic [7:0] inv_sbox(input logic [7:0] x);
		logic [7:0] tbl [256];
		tbl = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
		return tbl[x];
	endfunction

	// Forward S-box for key expansion, as a constant table.
	function automatic logic [7:0] fwd_sbox(input logic [7:0] x);
		logic [7:0] tbl [256];
		tbl = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return tbl[x];
	endfunction

	// Multiply by x in GF(2^8).
	function automatic logic [7:0] xt(input logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	// Inverse mix of one column; byte 0 is the most significant.
	function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
		logic [7:0] a [4];
		logic [7:0] x2 [4];
		logic [7:0] x4 [4];
		logic [7:0] x8 [4];
		logic [7:0] m9 [4];
		logic [7:0] mb [4];
		logic [7:0] md [4];
		logic [7:0] me [4];
		for (int i = 0; i < 4; i++) begin
			a[i]  = c[31-8*i -: 8];
			x2[i] = xt(a[i]);
			x4[i] = xt(x2[i]);
			x8[i] = xt(x4[i]);
			m9[i] = x8[i] ^ a[i];
			mb[i] = x8[i] ^ x2[i] ^ a[i];
			md[i] = x8[i] ^ x4[i] ^ a[i];
			me[i] = x8[i] ^ x4[i] ^ x2[i];
		end
		return {me[0] ^ mb[1] ^ md[2] ^ m9[3],
			m9[0] ^ me[1] ^ mb[2] ^ md[3],
			md[0] ^ m9[1] ^ me[2] ^ mb[3],
			mb[0] ^ md[1] ^ m9[2] ^ me[3]};
	endfunction

endpackage

[src/aesd_front.sv]
// Front end: pairs the two halves of a block and pushes whole blocks into a short queue.
// Depends on aesd_pkg.
module aesd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [63:0]          cipher_half,
	input  logic                 is_second,
	input  logic                 in_valid,
	output logic                 in_ready,
	output aesd_pkg::blk_t       q_data,
	output logic                 q_valid,
	input  logic                 q_ready
);
	import aesd_pkg::*;

	logic [HALF_W-1:0] held_q;
	logic              have_first_q;
	blk_t              slot_q [2];
	logic [1:0]        cnt_q;
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic              push;
	logic              pop;

	// Items are taken while the block queue has room.
	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready && is_second && have_first_q;
	assign pop      = q_valid && q_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_data   = slot_q[rd_ptr_q];

	// Held half and pairing flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q       <= '0;
			have_first_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			if (!is_second) begin
				held_q       <= cipher_half;
				have_first_q <= 1'b1;
			end else begin
				have_first_q <= 1'b0;
			end
		end
	end

	// Two-entry block queue.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q].block <= {held_q, cipher_half};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

[src/aesd_keys.sv]
// Key schedule: holds the key registers and expands one round key per cycle after reset or a write.
// Depends on aesd_pkg.
module aesd_keys (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [0:0]   cfg_index,
	input  logic [63:0]  cfg_data,
	output logic [127:0] rk [11],
	output logic         keys_ready
);
	import aesd_pkg::*;

	logic [127:0] rk_q [11];
	logic [3:0]   step_q;
	logic         busy_q;
	logic [7:0]   rc_q;
	logic [127:0] prev;
	logic [31:0]  t;
	logic [31:0]  w0, w1, w2, w3;
	logic [63:0]  ku, kl;

	assign cfg_ready  = 1'b1;
	assign rk         = rk_q;
	assign keys_ready = !busy_q;

	// Next round key from the previous one.
	always_comb begin
		prev = rk_q[step_q - 4'd1];
		t    = {fwd_sbox(prev[23:16]), fwd_sbox(prev[15:8]), fwd_sbox(prev[7:0]),
			fwd_sbox(prev[31:24])} ^ {rc_q, 24'h0};
		w0   = prev[127:96] ^ t;
		w1   = prev[95:64] ^ w0;
		w2   = prev[63:32] ^ w1;
		w3   = prev[31:0] ^ w2;
		ku   = (cfg_index == REG_KEY_UPPER) ? cfg_data : rk_q[0][127:64];
		kl   = (cfg_index == REG_KEY_LOWER) ? cfg_data : rk_q[0][63:0];
	end

	// Round key 0 is the key itself; a write restarts the expansion.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 11; i++) rk_q[i] <= '0;
			step_q <= 4'd1;
			busy_q <= 1'b1;
			rc_q   <= 8'h01;
		end else if (cfg_valid) begin
			rk_q[0] <= {ku, kl};
			step_q  <= 4'd1;
			busy_q  <= 1'b1;
			rc_q    <= 8'h01;
		end else if (busy_q) begin
			rk_q[step_q] <= {w0, w1, w2, w3};
			rc_q         <= xt(rc_q);
			step_q       <= step_q + 4'd1;
			if (step_q == 4'(NROUNDS)) busy_q <= 1'b0;
		end
	end
endmodule

[src/aesd_back.sv]
// Back end: runs the inverse cipher one round per cycle and emits two halves.
// Depends on aesd_pkg.
module aesd_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  aesd_pkg::blk_t       q_data,
	input  logic                 q_valid,
	output logic                 q_ready,
	input  logic [127:0]         rk [11],
	input  logic                 keys_ready,
	output logic [63:0]          plain_half,
	output logic                 last,
	output logic                 out_valid,
	input  logic                 out_ready
);
	import aesd_pkg::*;

	logic [127:0] st_q;
	logic [3:0]   rnd_q;
	logic         run_q;
	logic [127:0] res_q;
	logic [1:0]   pend_q;
	logic [127:0] sh;
	logic [127:0] sb;
	logic [127:0] ak;
	logic [127:0] mx;
	logic         done;
	logic         res_free;

	// Round logic: inverse shift rows, inverse S-box, key add, inverse mix.
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				sh[127-8*(c*4+r) -: 8] = st_q[127-8*(((c-r+4)%4)*4+r) -: 8];
			end
		end
		for (int i = 0; i < 16; i++) sb[127-8*i -: 8] = inv_sbox(sh[127-8*i -: 8]);
		ak = sb ^ rk[rnd_q - 4'd1];
		for (int c = 0; c < 4; c++) mx[127-32*c -: 32] = inv_mix_col(ak[127-32*c -: 32]);
	end

	// A new block starts only once the round keys are complete.
	assign done     = run_q && (rnd_q == 4'd1);
	assign res_free = (pend_q == 2'd0) || ((pend_q == 2'd1) && out_ready);
	assign q_ready  = keys_ready && (!run_q || (done && res_free));

	// Round state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			rnd_q <= '0;
		end else if (q_valid && q_ready) begin
			run_q <= 1'b1;
			rnd_q <= 4'(NROUNDS);
		end else if (run_q && !done) begin
			rnd_q <= rnd_q - 4'd1;
		end else if (done && res_free) begin
			run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_valid && q_ready) st_q <= q_data.block ^ rk[NROUNDS];
		else if (run_q && !done) st_q <= mx;
		if (done && res_free) res_q <= ak;
	end

	// Output register: two halves, first then second.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (done && res_free) begin
			pend_q <= 2'd2;
		end else if (out_valid && out_ready) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	assign out_valid  = (pend_q != 2'd0);
	assign last       = (pend_q == 2'd1);
	assign plain_half = last ? res_q[63:0] : res_q[127:64];
endmodule

[src/aes128_block_decrypt.sv]
// Top level of the AES-128 block decryptor.
// Depends on aesd_pkg, aesd_front, aesd_keys and aesd_back.
//
// channel | signals                                      | direction
// in      | in_valid, in_ready, cipher_half, is_second  | into block
// out     | out_valid, out_ready, plain_half, last      | out of block
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data   | into block
//
// The round unit works on one block at a time, one round per cycle, and takes the next block as
// it finishes the last. The front pairs halves and buffers two blocks, so it keeps taking items
// while the round unit works and while a result waits, until its queue is full. After reset or a
// key write the key schedule expands the round keys, and the round unit starts no block before
// it is done. Reset is asynchronous and clears all control state.
module aes128_block_decrypt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [63:0] cipher_half,
	input  logic        is_second,
	input  logic        in_valid,
	output logic        in_ready,
	output logic [63:0] plain_half,
	output logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import aesd_pkg::*;

	blk_t         q_data;
	logic         q_valid;
	logic         q_ready;
	logic [127:0] rk [11];
	logic         keys_ready;

	aesd_front u_front (
		.clk, .arst_n, .cipher_half, .is_second, .in_valid, .in_ready,
		.q_data, .q_valid, .q_ready
	);

	aesd_keys u_keys (
		.clk, .arst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .rk, .keys_ready
	);

	aesd_back u_back (
		.clk, .arst_n, .q_data, .q_valid, .q_ready, .rk, .keys_ready,
		.plain_half, .last, .out_valid, .out_ready
	);
endmodule
